/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the block allocator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/core/bba_pkg.sv */
// Package of the bitmap block allocator: sizes, widths and the
// controller/datapath command and status structs. No dependencies.
package bba_pkg;

  localparam int NUM_BLOCKS  = 1024;
  localparam int MAX_REQUEST = 64;
  localparam int WORD_W      = 32;
  localparam int NUM_WORDS   = NUM_BLOCKS / WORD_W;
  localparam int IDX_W       = $clog2(NUM_BLOCKS);
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int WADDR_W     = $clog2(NUM_WORDS);
  localparam int PTR_W       = $clog2(MAX_REQUEST);
  localparam int CNT_W       = 7;   // width of the request count field
  localparam int AB_W        = 11;  // width of the active block register
  localparam logic [AB_W-1:0] ACTIVE_RST = AB_W'(1024);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef struct packed {
    logic clear_map;   // free every block
    logic start_scan;  // latch count, rewind scan pointers
    logic take;        // record lowest free block of current word
    logic next_word;   // advance scan to the next map word
    logic emit;        // send one collected block and mark it used
    logic resp;        // send a single result without block
    logic resp_ok;     // success flag of that single result
  } bba_cmd_t;

  typedef struct packed {
    logic req_clear;
    logic req_zero;
    logic req_big;
    logic free_any;
    logic found_last;
    logic last_word;
    logic emit_last;
    logic out_free;
  } bba_stat_t;

endpackage

/* rtl/core/bba_ctrl.sv */
// Controller of the bitmap block allocator: request sequencing FSM.
// Depends on bba_pkg (command and status structs).
module bba_ctrl import bba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  bba_stat_t stat,
  output bba_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_SCAN      = 6'b000010,
    ST_PRIME     = 6'b000100,
    ST_EMIT      = 6'b001000,
    ST_RESP_OK   = 6'b010000,
    ST_RESP_FAIL = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.req_clear) begin
            cmd.clear_map = 1'b1;
            state_nxt     = ST_RESP_OK;
          end else if (stat.req_zero) begin
            state_nxt = ST_RESP_OK;
          end else if (stat.req_big) begin
            state_nxt = ST_RESP_FAIL;
          end else begin
            cmd.start_scan = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stat.free_any) begin
          cmd.take = 1'b1;
          if (stat.found_last) state_nxt = ST_PRIME;
        end else if (stat.last_word) begin
          state_nxt = ST_RESP_FAIL;
        end else begin
          cmd.next_word = 1'b1;
        end
      end
      // first pending entry is read out this cycle
      ST_PRIME: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) state_nxt = ST_IDLE;
        end
      end
      ST_RESP_OK: begin
        if (stat.out_free) begin
          cmd.resp    = 1'b1;
          cmd.resp_ok = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_RESP_FAIL: begin
        if (stat.out_free) begin
          cmd.resp  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/bba_datapath.sv */
// Datapath of the bitmap block allocator: usage map words, scan unit,
// pending index memory, configuration and output registers. Uses bba_pkg.
module bba_datapath import bba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  bba_cmd_t         cmd,
  output bba_stat_t        stat,
  input  logic             in_req_type,
  input  logic [CNT_W-1:0] in_request_count,
  input  logic             cfg_we,
  input  logic [AB_W-1:0]  cfg_data,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_block_index,
  output logic             out_has_block,
  output logic             out_success,
  output logic             out_last
);

  logic [WORD_W-1:0]  map_r [NUM_WORDS];
  logic [IDX_W-1:0]   pend_mem [MAX_REQUEST];
  logic [IDX_W-1:0]   rd_data_r;
  logic [PTR_W-1:0]   rd_addr;

  logic [AB_W-1:0]    active_r;
  logic [AB_W-1:0]    lim;
  logic [WADDR_W-1:0] word_r;
  logic [WORD_W-1:0]  taken_r;
  logic [CNT_W-1:0]   found_r;
  logic [CNT_W-1:0]   want_r;
  logic [PTR_W-1:0]   emit_ptr_r;

  logic [WORD_W-1:0]  act_mask;
  logic [WORD_W-1:0]  free_vec;
  logic [WORD_W-1:0]  lsb_vec;
  logic [BIT_W-1:0]   lsb_pos;
  logic [IDX_W-1:0]   take_idx;

  logic               out_valid_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic               out_has_r;
  logic               out_ok_r;
  logic               out_last_r;
  logic               out_free;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RST;
    end else if (cfg_we) begin
      active_r <= cfg_data;
    end
  end

  assign lim = (active_r > AB_W'(NUM_BLOCKS)) ? AB_W'(NUM_BLOCKS) : active_r;

  // Scan of the current word: free, active and not yet taken.
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      act_mask[b] = AB_W'({word_r, BIT_W'(b)}) < lim;
    end
    free_vec = ~map_r[word_r] & act_mask & ~taken_r;
    lsb_vec  = free_vec & (~free_vec + WORD_W'(1));
    lsb_pos  = '0;
    for (int b = 0; b < WORD_W; b++) begin
      lsb_pos = lsb_pos | (lsb_vec[b] ? BIT_W'(b) : BIT_W'(0));
    end
  end

  assign take_idx = {word_r, lsb_pos};

  // Scan pointers.
  always_ff @(posedge clk) begin
    if (cmd.start_scan) begin
      word_r     <= '0;
      taken_r    <= '0;
      found_r    <= '0;
      want_r     <= in_request_count;
      emit_ptr_r <= '0;
    end else begin
      if (cmd.take) begin
        taken_r <= taken_r | lsb_vec;
        found_r <= found_r + CNT_W'(1);
      end
      if (cmd.next_word) begin
        word_r  <= word_r + WADDR_W'(1);
        taken_r <= '0;
      end
      if (cmd.emit) emit_ptr_r <= emit_ptr_r + PTR_W'(1);
    end
  end

  // Usage map: a set bit is a used block.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_map) begin
      for (int w = 0; w < NUM_WORDS; w++) map_r[w] <= '0;
    end else if (cmd.emit) begin
      map_r[rd_data_r[IDX_W-1:BIT_W]][rd_data_r[BIT_W-1:0]] <= 1'b1;
    end
  end

  // Pending index memory, registered read.
  assign rd_addr = cmd.emit ? emit_ptr_r + PTR_W'(1) : emit_ptr_r;

  always_ff @(posedge clk) begin
    if (cmd.take) pend_mem[found_r[PTR_W-1:0]] <= take_idx;
    rd_data_r <= pend_mem[rd_addr];
  end

  // Output register.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.resp) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_idx_r  <= rd_data_r;
      out_has_r  <= 1'b1;
      out_ok_r   <= 1'b1;
      out_last_r <= stat.emit_last;
    end else if (cmd.resp) begin
      out_idx_r  <= '0;
      out_has_r  <= 1'b0;
      out_ok_r   <= cmd.resp_ok;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_block_index = out_idx_r;
  assign out_has_block   = out_has_r;
  assign out_success     = out_ok_r;
  assign out_last        = out_last_r;

  // Status toward the controller.
  always_comb begin
    stat            = '0;
    stat.req_clear  = (in_req_type == REQ_CLEAR);
    stat.req_zero   = (in_request_count == '0);
    stat.req_big    = (in_request_count > CNT_W'(MAX_REQUEST));
    stat.free_any   = |free_vec;
    stat.found_last = ((found_r + CNT_W'(1)) == want_r);
    stat.last_word  = (word_r == WADDR_W'(NUM_WORDS - 1));
    stat.emit_last  = ((CNT_W'(emit_ptr_r) + CNT_W'(1)) == want_r);
    stat.out_free   = out_free;
  end

endmodule

/* rtl/core/bitmap_block_allocator.sv */
// Top level of the bitmap first-fit block allocator.
// Depends on bba_pkg, bba_ctrl, bba_datapath and assert_macros.svh.
//
// Input channel (in_valid / in_stall): one request per accepted beat;
//   in_req_type selects allocate or clear, in_request_count the blocks wanted.
// Output channel (out_valid / out_stall): one result per allocated block in
//   ascending index order, out_last on the final one; a clear, a zero count,
//   an oversized count or a shortage of free blocks gives one result without
//   block. cfg_active_blocks (cfg_valid / cfg_ready, ready always high) sets
//   how many blocks, counted from index zero, are managed.
// Timing: a single-result request goes from acceptance through its response
//   state into the output register once the output is free, and the next
//   request is taken once the block is back in idle. An allocate of N blocks
//   scans the map words (one take or one word step per cycle), reads out the
//   first collected index in the prime state, then gives one result per cycle
//   while the output is not stalled; the next request is taken once the block
//   is back in idle. One request is worked on at a time.
// Reset: every block is free and 1024 blocks are active. A stalled output
//   holds its result; nothing is lost.
`include "assert_macros.svh"

module bitmap_block_allocator import bba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic [CNT_W-1:0] in_request_count,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [IDX_W-1:0] out_block_index,
  output logic             out_has_block,
  output logic             out_success,
  output logic             out_last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [AB_W-1:0]  cfg_active_blocks
);

  bba_cmd_t  cmd;
  bba_stat_t stat;

  // Register writes are taken at any time.
  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_req_type      (in_req_type),
    .in_request_count (in_request_count),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_active_blocks),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_block_index  (out_block_index),
    .out_has_block    (out_has_block),
    .out_success      (out_success),
    .out_last         (out_last)
  );

  // An accepted request always makes the block busy in the cycle after acceptance.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // A result carrying a block is always a success.
  `ASSERT_IMPL(a_block_is_success, clk, rst_n, out_valid && out_has_block, out_success)
  // A result without block ends its request.
  `ASSERT_IMPL(a_noblock_is_last, clk, rst_n, out_valid && !out_has_block, out_last)
  // A failure never reports an index.
  `ASSERT_IMPL(a_fail_zero_index, clk, rst_n, out_valid && !out_success,
               out_block_index == '0)

endmodule

/* tb/bitmap_block_allocator_tb.sv */
// Self-checking testbench of bitmap_block_allocator: issues allocate and clear
// requests, keeps its own first-fit copy of the usage map and checks each result.
// Depends on bba_pkg and the RTL of the allocator; needs nothing else.
module bitmap_block_allocator_tb;
  import bba_pkg::*;

  // One result beat as the output channel shows it.
  typedef struct packed {
    logic [IDX_W-1:0] block_index;
    logic             has_block;
    logic             success;
    logic             last;
  } alloc_result_t;

  logic             clk;
  logic             rst_n            = 1'b0;
  logic             in_valid         = 1'b0;
  logic             in_stall;
  logic             in_req_type      = REQ_ALLOC;
  logic [CNT_W-1:0] in_request_count = '0;
  logic             out_valid;
  logic             out_stall        = 1'b0;
  logic [IDX_W-1:0] out_block_index;
  logic             out_has_block;
  logic             out_success;
  logic             out_last;
  logic             cfg_valid        = 1'b0;
  logic             cfg_ready;
  logic [AB_W-1:0]  cfg_active_blocks = '0;

  bitmap_block_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_request_count (in_request_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_block_index  (out_block_index),
    .out_has_block    (out_has_block),
    .out_success      (out_success),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_active_blocks(cfg_active_blocks)
  );

  // Shadow of the allocator: usage map (set = used), managed block count and
  // the results still owed by the block, oldest first.
  bit              block_in_use [NUM_BLOCKS];
  logic [AB_W-1:0] managed_blocks = ACTIVE_RST;
  alloc_result_t   alloc_results_q [$];
  int              mismatch_cnt = 0;
  bit              steady = 1'b0;  // when set, neither side idles

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("bitmap_block_allocator test failed");
    $finish;
  end

  // Stall the result channel in about a fifth of the cycles.
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 21);
  end

  task automatic flag_mismatch(string what);
    mismatch_cnt++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [IDX_W-1:0] got, logic [IDX_W-1:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // First-fit allocation on the shadow map: queue the results that one
  // accepted request owes, and update the map the same way the block does.
  function automatic void allocate_first_fit(logic kind, logic [CNT_W-1:0] want);
    int limit;
    int picks [$];
    if (kind == REQ_CLEAR) begin
      // Free every block, including those beyond the managed count.
      foreach (block_in_use[i]) block_in_use[i] = 1'b0;
      alloc_results_q.push_back('{'0, 1'b0, 1'b1, 1'b1});
      return;
    end
    if (want == 0) begin
      alloc_results_q.push_back('{'0, 1'b0, 1'b1, 1'b1});
      return;
    end
    // An oversized request fails like a shortage.
    if (want > MAX_REQUEST) begin
      alloc_results_q.push_back('{'0, 1'b0, 1'b0, 1'b1});
      return;
    end
    // Saturate the managed count at the map size.
    limit = (managed_blocks > NUM_BLOCKS) ? NUM_BLOCKS : int'(managed_blocks);
    for (int i = 0; i < limit && picks.size() < want; i++) begin
      if (!block_in_use[i]) picks.push_back(i);
    end
    if (picks.size() < want) begin
      alloc_results_q.push_back('{'0, 1'b0, 1'b0, 1'b1});
      return;
    end
    foreach (picks[k]) begin
      block_in_use[picks[k]] = 1'b1;
      alloc_results_q.push_back('{IDX_W'(picks[k]), 1'b1, 1'b1, k == picks.size() - 1});
    end
  endfunction

  // Compare each accepted result with the oldest one owed.
  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (alloc_results_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: index %0d has %0b ok %0b last %0b",
                                out_block_index, out_has_block, out_success, out_last));
      end else begin
        want = alloc_results_q.pop_front();
        check_field("block_index", out_block_index, want.block_index);
        check_field("has_block", out_has_block, want.has_block);
        check_field("success", out_success, want.success);
        check_field("last", out_last, want.last);
      end
    end
  end

  // Send one request; hold it until the block takes it, then log what it owes.
  // Valid stays high afterward so back-to-back requests need no drop.
  task automatic issue_request(logic kind, logic [CNT_W-1:0] count);
    @(negedge clk);
    if (!steady && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= kind;
    in_request_count <= count;
    do @(posedge clk); while (in_stall);
    allocate_first_fit(kind, count);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (alloc_results_q.size() != 0) @(posedge clk);
  endtask

  // Write the managed block count while the block is idle.
  task automatic set_managed_blocks(logic [AB_W-1:0] count);
    drain_requests();
    // Let the block settle back to idle after its last result.
    repeat (4) @(negedge clk);
    cfg_valid         <= 1'b1;
    cfg_active_blocks <= count;
    do @(posedge clk); while (!cfg_ready);
    managed_blocks = count;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Out of reset: zero, full and oversized counts, a clear with a count.
  task automatic test_reset_defaults();
    issue_request(REQ_ALLOC, 7'd1);
    issue_request(REQ_ALLOC, 7'd0);
    issue_request(REQ_ALLOC, 7'd64);
    issue_request(REQ_ALLOC, 7'd65);
    issue_request(REQ_ALLOC, 7'd127);
    issue_request(REQ_CLEAR, 7'd127);
    issue_request(REQ_ALLOC, 7'd64);
  endtask

  // Smallest legal map: exact fit, shortage, and a request above the map size.
  task automatic test_small_map();
    set_managed_blocks(11'd8);
    issue_request(REQ_ALLOC, 7'd3);
    issue_request(REQ_ALLOC, 7'd5);
    issue_request(REQ_ALLOC, 7'd1);
    issue_request(REQ_CLEAR, 7'd0);
    issue_request(REQ_ALLOC, 7'd8);
    issue_request(REQ_CLEAR, 7'd0);
    issue_request(REQ_ALLOC, 7'd9);
  endtask

  // Counts below the low bound: zero blocks and a single block.
  task automatic test_tiny_maps();
    set_managed_blocks(11'd0);
    issue_request(REQ_ALLOC, 7'd1);
    issue_request(REQ_ALLOC, 7'd0);
    set_managed_blocks(11'd1);
    issue_request(REQ_ALLOC, 7'd1);
    issue_request(REQ_ALLOC, 7'd1);
  endtask

  // Blocks past the managed count keep their bits; a clear frees them anyway.
  task automatic test_beyond_active();
    set_managed_blocks(11'd1024);
    issue_request(REQ_CLEAR, 7'd0);
    issue_request(REQ_ALLOC, 7'd10);
    set_managed_blocks(11'd8);
    issue_request(REQ_ALLOC, 7'd1);
    set_managed_blocks(11'd1024);
    issue_request(REQ_ALLOC, 7'd2);
    set_managed_blocks(11'd8);
    issue_request(REQ_CLEAR, 7'd0);
    set_managed_blocks(11'd1024);
    issue_request(REQ_ALLOC, 7'd4);
  endtask

  // Oversized count saturates: fill all 1024 blocks, then one more must fail.
  task automatic test_fill_to_saturation();
    set_managed_blocks(11'd2047);
    issue_request(REQ_CLEAR, 7'd0);
    repeat (NUM_BLOCKS / MAX_REQUEST) issue_request(REQ_ALLOC, 7'(MAX_REQUEST));
    issue_request(REQ_ALLOC, 7'd1);
    issue_request(REQ_CLEAR, 7'd0);
  endtask

  // Mostly small allocations with random content, some large ones, and a
  // sprinkle of clears, zero and oversized counts, over several map sizes.
  task automatic test_random_traffic();
    logic [AB_W-1:0] sizes [9] = '{11'd2047, 11'd1024, 11'd8, 11'd37, 11'd300,
                                   11'd1, 11'd0, 11'd1024, 11'd2047};
    int roll;
    foreach (sizes[p]) begin
      set_managed_blocks(sizes[p]);
      // Run one phase with no idling on either side.
      steady = (p == 1);
      repeat (35) begin
        roll = $urandom_range(99);
        if (roll < 6)
          issue_request(REQ_CLEAR, 7'($urandom_range(127)));
        else if (roll < 8)
          issue_request(REQ_ALLOC, 7'd0);
        else if (roll < 11)
          issue_request(REQ_ALLOC, 7'($urandom_range(127, 65)));
        else if (roll < 75)
          issue_request(REQ_ALLOC, 7'($urandom_range(8, 1)));
        else
          issue_request(REQ_ALLOC, 7'($urandom_range(64, 1)));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    // Hold reset, then release it at a falling edge.
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_small_map();
    test_tiny_maps();
    test_beyond_active();
    test_fill_to_saturation();
    test_random_traffic();

    drain_requests();
    // Wait out the longest request latency to catch stray results.
    repeat (200) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("bitmap_block_allocator test passed");
    else
      $display("bitmap_block_allocator test failed");
    $finish;
  end

endmodule
